/* design/vac_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vac_pkg
// Shared types for the vector angle cosine pipeline.
// ----------------------------------------------------------------------------
package vac_pkg;

  // Sideband that rides along with every item through the pipeline
  typedef struct packed {
    logic neg;    // dot product is negative
    logic degen;  // one of the vectors has zero length
  } vac_flags_t;

  // Radicand bits consumed per square root step
  localparam int unsigned SqrtDigitBits = 2;

endpackage
`default_nettype wire

/* design/vector_angle_cosine_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vector_angle_cosine_core
// Cosine of the angle at an apex between two 2D points, signed Q1.F result.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i/in_ready_o, end*, apex*   | item in
//  out     | out_valid_o/out_ready_i, cosine,degen| item out
//
//  One item per cycle while the output item is taken; one square root digit
//  and one quotient bit are resolved per stage. The whole pipeline holds
//  while the output item is not taken; reset clears only the valid bits.
// ----------------------------------------------------------------------------
module vector_angle_cosine_core #(
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned COS_FRAC_BITS = 15
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  [COORD_BITS-1:0]     end0_x_i,
  input  wire  [COORD_BITS-1:0]     end0_y_i,
  input  wire  [COORD_BITS-1:0]     end1_x_i,
  input  wire  [COORD_BITS-1:0]     end1_y_i,
  input  wire  [COORD_BITS-1:0]     apex_x_i,
  input  wire  [COORD_BITS-1:0]     apex_y_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic [COS_FRAC_BITS:0]    cosine_q15_o,
  output logic                      degenerate_o
);
  import vac_pkg::*;

  localparam int unsigned D   = COORD_BITS + 1;      // difference width
  localparam int unsigned AW  = 2 * COORD_BITS + 2;  // squared length width
  localparam int unsigned LW  = COORD_BITS + 1;      // low half of split
  localparam int unsigned HW  = AW - LW;             // high half of split
  localparam int unsigned PW  = 2 * AW;              // product width
  localparam int unsigned RW  = PW / SqrtDigitBits;  // square root steps
  localparam int unsigned NQ  = COS_FRAC_BITS + 1;   // quotient bits
  localparam int unsigned F   = COS_FRAC_BITS;

  logic adv;
  assign adv        = ~out_valid_o | out_ready_i;
  assign in_ready_o = adv;

  // ---------------- stage 1: differences ----------------
  logic                v1_q;
  logic signed [D-1:0] ax_q, ay_q, bx_q, by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= {end0_x_i[COORD_BITS-1], end0_x_i} - {apex_x_i[COORD_BITS-1], apex_x_i};
      ay_q <= {end0_y_i[COORD_BITS-1], end0_y_i} - {apex_y_i[COORD_BITS-1], apex_y_i};
      bx_q <= {end1_x_i[COORD_BITS-1], end1_x_i} - {apex_x_i[COORD_BITS-1], apex_x_i};
      by_q <= {end1_y_i[COORD_BITS-1], end1_y_i} - {apex_y_i[COORD_BITS-1], apex_y_i};
    end
  end

  // ---------------- stage 2: products ----------------
  logic                  v2_q;
  logic signed [2*D-1:0] paa_x_q, paa_y_q, pbb_x_q, pbb_y_q, pab_x_q, pab_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      paa_x_q <= ax_q * ax_q;
      paa_y_q <= ay_q * ay_q;
      pbb_x_q <= bx_q * bx_q;
      pbb_y_q <= by_q * by_q;
      pab_x_q <= ax_q * bx_q;
      pab_y_q <= ay_q * by_q;
    end
  end

  // ---------------- stage 3: sums, sign, magnitude ----------------
  logic                  v3_q;
  logic [AW-1:0]         a2_q, b2_q, mag3_q;
  vac_flags_t            flg3_q;
  logic signed [2*D:0]   a2_s, b2_s, dot_s;
  logic [2*D:0]          dot_abs;

  always_comb begin
    a2_s    = {paa_x_q[2*D-1], paa_x_q} + {paa_y_q[2*D-1], paa_y_q};
    b2_s    = {pbb_x_q[2*D-1], pbb_x_q} + {pbb_y_q[2*D-1], pbb_y_q};
    dot_s   = {pab_x_q[2*D-1], pab_x_q} + {pab_y_q[2*D-1], pab_y_q};
    dot_abs = dot_s[2*D] ? -dot_s : dot_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a2_q         <= a2_s[AW-1:0];
      b2_q         <= b2_s[AW-1:0];
      mag3_q       <= dot_abs[AW-1:0];
      flg3_q.neg   <= dot_s[2*D];
      flg3_q.degen <= (a2_s[AW-1:0] == '0) || (b2_s[AW-1:0] == '0);
    end
  end

  // ---------------- stage 4: partial products of a2 * b2 ----------------
  logic              v4_q;
  logic [2*LW-1:0]   pp_ll_q;
  logic [LW+HW-1:0]  pp_lh_q, pp_hl_q;
  logic [2*HW-1:0]   pp_hh_q;
  logic [AW-1:0]     mag4_q;
  vac_flags_t        flg4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_ll_q <= a2_q[LW-1:0]  * b2_q[LW-1:0];
      pp_lh_q <= a2_q[LW-1:0]  * b2_q[AW-1:LW];
      pp_hl_q <= a2_q[AW-1:LW] * b2_q[LW-1:0];
      pp_hh_q <= a2_q[AW-1:LW] * b2_q[AW-1:LW];
      mag4_q  <= mag3_q;
      flg4_q  <= flg3_q;
    end
  end

  // ---------------- stage 5: full product ----------------
  logic          v5_q;
  logic [PW-1:0] prod_q;
  logic [AW-1:0] mag5_q;
  vac_flags_t    flg5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= (PW'(pp_hh_q) << (2 * LW)) + (PW'(pp_lh_q) << LW)
              + (PW'(pp_hl_q) << LW) + PW'(pp_ll_q);
      mag5_q <= mag4_q;
      flg5_q <= flg4_q;
    end
  end

  // ---------------- square root: two radicand bits per stage ----------------
  logic             sq_v   [0:RW];
  logic [PW-1:0]    sq_n   [0:RW];
  logic [AW+1:0]    sq_rem [0:RW];
  logic [AW-1:0]    sq_root[0:RW];
  logic [AW-1:0]    sq_mag [0:RW];
  vac_flags_t       sq_flg [0:RW];

  assign sq_v[0]    = v5_q;
  assign sq_n[0]    = prod_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_mag[0]  = mag5_q;
  assign sq_flg[0]  = flg5_q;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [AW+3:0] cur, trial, diff;
    logic [AW+1:0] rem_d;
    logic [AW-1:0] root_d;

    always_comb begin
      cur   = {sq_rem[k], sq_n[k][PW-1 -: 2]};
      trial = {2'b00, sq_root[k], 2'b01};
      diff  = cur - trial;
      if (cur >= trial) begin
        // remainder stays at or below twice the root
        rem_d  = diff[AW+1:0];
        root_d = {sq_root[k][AW-2:0], 1'b1};
      end else begin
        rem_d  = cur[AW+1:0];
        root_d = {sq_root[k][AW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v[k+1] <= 1'b0;
      else if (adv) sq_v[k+1] <= sq_v[k];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_n[k+1]    <= sq_n[k] << 2;
        sq_rem[k+1]  <= rem_d;
        sq_root[k+1] <= root_d;
        sq_mag[k+1]  <= sq_mag[k];
        sq_flg[k+1]  <= sq_flg[k];
      end
    end
  end

  // ---------------- division: one quotient bit per stage ----------------
  // The magnitude never exceeds the root, so the quotient fits F+1 bits.
  logic             dv_v   [0:NQ];
  logic [AW:0]      dv_rem [0:NQ];
  logic [AW-1:0]    dv_root[0:NQ];
  logic [NQ-1:0]    dv_q   [0:NQ];
  vac_flags_t       dv_flg [0:NQ];

  assign dv_v[0]    = sq_v[RW];
  assign dv_rem[0]  = {1'b0, sq_mag[RW]};
  assign dv_root[0] = sq_root[RW];
  assign dv_q[0]    = '0;
  assign dv_flg[0]  = sq_flg[RW];

  for (genvar j = 0; j < NQ; j++) begin : g_div
    logic [AW:0] cur, dvs;
    logic [AW:0] rem_d;
    logic        qbit;

    if (j == 0) begin : g_first
      assign cur = dv_rem[j];
    end else begin : g_next
      assign cur = {dv_rem[j][AW-1:0], 1'b0};
    end

    always_comb begin
      dvs  = {1'b0, dv_root[j]};
      qbit = (cur >= dvs);
      rem_d = qbit ? (cur - dvs) : cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v[j+1] <= 1'b0;
      else if (adv) dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem[j+1]  <= rem_d;
        dv_root[j+1] <= dv_root[j];
        dv_q[j+1]    <= {dv_q[j][NQ-2:0], qbit};
        dv_flg[j+1]  <= dv_flg[j];
      end
    end
  end

  // ---------------- output stage: sign and saturation ----------------
  logic          out_v_q;
  logic [F:0]    cos_q;
  logic          degen_q;
  logic [F:0]    cos_d;
  logic [F:0]    qfin;

  always_comb begin
    qfin = dv_q[NQ];
    priority if (dv_flg[NQ].degen) begin
      cos_d = '0;
    end else if (dv_flg[NQ].neg) begin
      cos_d = -qfin;
    end else if (qfin[F]) begin
      cos_d = {1'b0, {F{1'b1}}};
    end else begin
      cos_d = qfin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= dv_v[NQ];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cos_q   <= cos_d;
      degen_q <= dv_flg[NQ].degen;
    end
  end

  assign out_valid_o  = out_v_q;
  assign cosine_q15_o = cos_q;
  assign degenerate_o = degen_q;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> cosine_q15_o == '0)
    else $error("degenerate item with nonzero cosine");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cosine_q15_o))
    else $error("output item changed while stalled");

  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v[RW] |-> sq_rem[RW] <= {1'b0, sq_root[RW], 1'b0})
    else $error("square root remainder out of range");

  a_quot_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v[NQ] && !dv_flg[NQ].degen |-> dv_q[NQ] <= {1'b1, {F{1'b0}}})
    else $error("quotient above one");
`endif

endmodule
`default_nettype wire
